/* design/tmrc_pkg.sv */
// Shared types and constants for the tile map rectangle collision core.
// No dependencies; imported by tile_map_rect_collision_core and its testbench.
package tmrc_pkg;

    // Tile code width and the code that marks a solid tile
    localparam int TILE_W = 8;
    localparam logic [TILE_W-1:0] SOLID_CODE = 8'd1;

    // Item kind carried on s_tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Input and output beat widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 8;

    // Pixel sums (coordinate plus extent) need one bit above the 12-bit inputs
    localparam int SUM_W = 13;
    localparam int QUO_W = SUM_W + 1;

    typedef logic signed [SUM_W-1:0] pix_sum_t;
    typedef logic signed [QUO_W-1:0] tile_idx_t;

endpackage

/* design/tmrc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tmrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/tile_map_rect_collision_core.sv */
// Top level of the tile map rectangle collision core: tile map RAM and scan sequencer.
// Depends on tmrc_pkg and tmrc_ram.
//
//  channel  | dir | tdata fields (low bit up)                          | tuser
//  ---------+-----+----------------------------------------------------+-------
//  s_*      | in  | tile_row, tile_col, tile_value, rect_x, rect_y,    | mode
//           |     | rect_w, rect_h, one pad bit                        |
//  m_*      | out | hit, seven pad bits                                | -
//
// A write beat writes the map RAM directly.
// A query clamps its tile range and scans it, or skips the scan for an empty range;
// the scan reads one tile per cycle through the single RAM read port and stops in the
// cycle a solid tile comes back.
// The result sits in an output register, so the next beat is taken while it waits; a
// query reaching its end waits for that register to free.
// Reset clears control state only; the map is undefined until written.
module tile_map_rect_collision_core #(
    parameter int ROWS       = 16,
    parameter int COLS       = 32,
    parameter int TILE_SHIFT = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tile_row[3:0] tile_col[8:4] tile_value[16:9] rect_x[28:17] rect_y[40:29]
    // rect_w[51:41] rect_h[62:52] pad[63]
    input  logic [tmrc_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit[0] pad[7:1]
    output logic [tmrc_pkg::M_TDATA_W-1:0]  m_tdata
);

    import tmrc_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

    localparam tile_idx_t ROW_MAX = QUO_W'(ROWS - 1);
    localparam tile_idx_t COL_MAX = QUO_W'(COLS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Input beat fields
    logic [3:0]        tile_row;
    logic [4:0]        tile_col;
    logic [TILE_W-1:0] tile_value;
    logic [11:0]       rect_x;
    logic [11:0]       rect_y;
    logic [10:0]       rect_w;
    logic [10:0]       rect_h;

    assign tile_row   = s_tdata[3:0];
    assign tile_col   = s_tdata[8:4];
    assign tile_value = s_tdata[16:9];
    assign rect_x     = s_tdata[28:17];
    assign rect_y     = s_tdata[40:29];
    assign rect_w     = s_tdata[51:41];
    assign rect_h     = s_tdata[62:52];

    logic [2:0]        state_reg, state_next;
    pix_sum_t          ny0_reg, ny0_next;
    pix_sum_t          ny1_reg, ny1_next;
    pix_sum_t          nx0_reg, nx0_next;
    pix_sum_t          nx1_reg, nx1_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [RW-1:0]     last_row_reg, last_row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     first_col_reg, first_col_next;
    logic [CW-1:0]     last_col_reg, last_col_next;
    logic [AW-1:0]     base_reg, base_next;
    logic              pend_reg, pend_next;
    logic              hit_acc_reg, hit_acc_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_hit_reg, m_hit_next;

    logic              s_accept;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [TILE_W-1:0] ram_rdata;
    logic              hit_now;

    tile_idx_t         qr0, qr1, qc0, qc1;
    tile_idx_t         r0c, r1c, c0c, c1c;
    logic              range_empty;
    logic [31:0]       base_full;

    // Signed divide by the tile size, truncated toward zero
    function automatic tile_idx_t tile_div(input pix_sum_t n);
        logic [SUM_W-1:0] mag;
        tile_idx_t        q;
        mag = n[SUM_W-1] ? SUM_W'(-n) : SUM_W'(n);
        q   = signed'({1'b0, mag >> TILE_SHIFT});
        return n[SUM_W-1] ? -q : q;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Write beats in range go straight to the map
    assign ram_we    = s_accept && (s_tuser == MODE_WRITE)
                       && (32'(tile_row) < ROWS) && (32'(tile_col) < COLS);
    assign ram_waddr = AW'(32'(tile_row) * COLS + 32'(tile_col));
    assign ram_raddr = base_reg + AW'(col_reg);

    tmrc_ram #(
        .WIDTH (TILE_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tile_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Tile bounds from the stored pixel sums
    always_comb
    begin
        qr0 = tile_div(ny0_reg);
        qr1 = tile_div(ny1_reg);
        qc0 = tile_div(nx0_reg);
        qc1 = tile_div(nx1_reg);
        r0c = qr0[QUO_W-1] ? '0 : qr0;
        c0c = qc0[QUO_W-1] ? '0 : qc0;
        r1c = (qr1 > ROW_MAX) ? ROW_MAX : qr1;
        c1c = (qc1 > COL_MAX) ? COL_MAX : qc1;
        range_empty = (r0c > r1c) || (c0c > c1c);
        base_full   = 32'(r0c[RW-1:0]) * COLS;
    end

    assign hit_now = pend_reg && (ram_rdata == SOLID_CODE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ny0_next       = ny0_reg;
        ny1_next       = ny1_reg;
        nx0_next       = nx0_reg;
        nx1_next       = nx1_reg;
        row_next       = row_reg;
        last_row_next  = last_row_reg;
        col_next       = col_reg;
        first_col_next = first_col_reg;
        last_col_next  = last_col_reg;
        base_next      = base_reg;
        pend_next      = 1'b0;
        hit_acc_next   = hit_acc_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_hit_next     = m_hit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the pixel sums of a query beat
                if (s_accept && (s_tuser == MODE_QUERY))
                begin
                    ny0_next   = {rect_y[11], rect_y} - SUM_W'(1);
                    nx0_next   = {rect_x[11], rect_x} - SUM_W'(1);
                    ny1_next   = {rect_y[11], rect_y} + signed'({2'b00, rect_h}) - SUM_W'(1);
                    nx1_next   = {rect_x[11], rect_x} + signed'({2'b00, rect_w}) - SUM_W'(1);
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                // Clamp bounds and load the scan position
                hit_acc_next   = 1'b0;
                row_next       = r0c[RW-1:0];
                last_row_next  = r1c[RW-1:0];
                col_next       = c0c[CW-1:0];
                first_col_next = c0c[CW-1:0];
                last_col_next  = c1c[CW-1:0];
                base_next      = AW'(base_full);
                state_next     = range_empty ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                if (hit_now)
                begin
                    // Stop on the first solid tile
                    hit_acc_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    // Issue this read and advance the position
                    pend_next = 1'b1;
                    if (col_reg == last_col_reg)
                    begin
                        col_next = first_col_reg;
                        if (row_reg == last_row_reg)
                        begin
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            row_next  = RW'(row_reg + 1'b1);
                            base_next = base_reg + AW'(COLS);
                        end
                    end
                    else
                    begin
                        col_next = CW'(col_reg + 1'b1);
                    end
                end
            end
            S_DRAIN:
            begin
                // Check the last read in flight
                if (hit_now)
                begin
                    hit_acc_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_hit_next   = hit_acc_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ny0_reg       <= ny0_next;
        ny1_reg       <= ny1_next;
        nx0_reg       <= nx0_next;
        nx1_reg       <= nx1_next;
        row_reg       <= row_next;
        last_row_reg  <= last_row_next;
        col_reg       <= col_next;
        first_col_reg <= first_col_next;
        last_col_reg  <= last_col_next;
        base_reg      <= base_next;
        hit_acc_reg   <= hit_acc_next;
        m_hit_reg     <= m_hit_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, m_hit_reg};

    // A new result appears only out of the final sequencer state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the final state");

    // The scan position never runs past the clamped bounds
    a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (row_reg <= last_row_reg) && (col_reg <= last_col_reg)
                                  && (col_reg >= first_col_reg))
        else $error("scan position out of bounds");

    // Map writes happen only while the sequencer is idle
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("map write while busy");

    // A read in flight is only checked in the scan or drain states
    a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SCAN) || (state_reg == S_DRAIN))
        else $error("read pending outside the scan");

endmodule

/* tb/tb_tile_map_rect_collision_core.sv */
// Self-checking testbench for tile_map_rect_collision_core: tile writes and rectangle queries.
// Depends on tmrc_pkg and the core RTL; the expected hit flags come from a shadow tile map.
module tb_tile_map_rect_collision_core;

    timeunit 1ns;
    timeprecision 1ps;

    import tmrc_pkg::*;

    localparam int ROWS        = 16;
    localparam int COLS        = 32;
    localparam int TILE_SHIFT  = 5;
    localparam int TILE_PIX    = 1 << TILE_SHIFT;
    localparam int MAX_IDLE    = 16;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 700;
    localparam int RANDOM_BEATS = 1200;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int SHOW_LIMIT  = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = MODE_WRITE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Shadow of the tile map and the hit flags still owed by the core
    logic [TILE_W-1:0]      tile_shadow [ROWS*COLS];
    logic                   hit_due_q [$];

    bit                     idle_on = 1'b1;
    bit                     hold_go = 1'b0;
    logic                   rx_hold = 1'b0;
    int                     mismatch_cnt = 0;
    int                     cycle_cnt = 0;

    tile_map_rect_collision_core #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .TILE_SHIFT (TILE_SHIFT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tile_map_rect_collision_core regression: fail");
            $finish;
        end
    end

    // Work out whether any tile under the rectangle holds the solid code
    function automatic logic rect_hits_solid(input logic signed [11:0] x,
                                             input logic signed [11:0] y,
                                             input logic [10:0] w,
                                             input logic [10:0] h);
        int xi, yi, wi, hi, r0, r1, c0, c1;
        logic found;
        xi = int'(x);
        yi = int'(y);
        wi = int'(w);
        hi = int'(h);
        found = 1'b0;
        // Signed quotients truncate toward zero
        r0 = (yi - 1) / TILE_PIX;
        c0 = (xi - 1) / TILE_PIX;
        r1 = (yi + hi - 1) / TILE_PIX;
        c1 = (xi + wi - 1) / TILE_PIX;
        if (r0 < 0) r0 = 0;
        if (c0 < 0) c0 = 0;
        if (r1 > ROWS - 1) r1 = ROWS - 1;
        if (c1 > COLS - 1) c1 = COLS - 1;
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
                if (tile_shadow[r*COLS + c] == SOLID_CODE)
                    found = 1'b1;
        return found;
    endfunction

    // Offer one beat after a random gap, hold it until taken, then update the shadow or owed hits
    task automatic send_item(input logic mode, input logic [3:0] row, input logic [4:0] col,
                             input logic [7:0] val, input logic signed [11:0] x,
                             input logic signed [11:0] y, input logic [10:0] w,
                             input logic [10:0] h);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, h, w, y, x, val, col, row};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (mode == MODE_WRITE)
        begin
            if (row < ROWS && col < COLS)
                tile_shadow[row*COLS + col] = val;
        end
        else
            hit_due_q.push_back(rect_hits_solid(x, y, w, h));
    endtask

    // Tile write with junk in the rectangle fields
    task automatic write_tile(input int row, input int col, input int val);
        send_item(MODE_WRITE, row[3:0], col[4:0], val[7:0], 12'($urandom()), 12'($urandom()),
                  11'($urandom()), 11'($urandom()));
    endtask

    // Rectangle query with junk in the tile fields
    task automatic query_rect(input int x, input int y, input int w, input int h);
        send_item(MODE_QUERY, 4'($urandom()), 5'($urandom()), 8'($urandom()), x[11:0], y[11:0],
                  w[10:0], h[10:0]);
    endtask

    // Compare each result beat with the oldest owed hit flag; draw a stall per beat
    initial
    begin : result_check
        int stall_left;
        logic want;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (hit_due_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOW_LIMIT)
                        $display("unexpected result beat: hit=%0b", m_tdata[0]);
                end
                else
                begin
                    want = hit_due_q.pop_front();
                    if (m_tdata[0] !== want)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= SHOW_LIMIT)
                            $display("hit mismatch: expected %0b, got %0b", want, m_tdata[0]);
                    end
                end
                stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (rx_hold || stall_left > 0)
            begin
                m_tready <= 1'b0;
                if (stall_left > 0)
                    stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Hold the result side off for a long stretch once asked
    initial
    begin : long_hold
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // The map has no reset: load every tile with a non-solid code before any query
    task automatic test_map_load();
        int v;
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
            begin
                v = $urandom_range(0, 255);
                if (v == SOLID_CODE)
                    v = 0;
                write_tile(r, c, v);
            end
        write_tile(0, 1, 255);
        write_tile(1, 0, 0);
    endtask

    // Rectangles wholly off the map scan nothing
    task automatic test_empty_ranges();
        query_rect(-2048, -2048, 0, 0);
        query_rect(2047, 2047, 2047, 2047);
        query_rect(1100, 0, 2047, 10);
    endtask

    // Scan the whole map, clear and then with a solid tile in the far corner
    task automatic test_full_map_scan();
        query_rect(0, 0, 2047, 2047);
        write_tile(ROWS-1, COLS-1, int'(SOLID_CODE));
        query_rect(0, 0, 2047, 2047);
        write_tile(ROWS-1, COLS-1, 0);
    endtask

    // Single-tile rectangles at the origin corner
    task automatic test_single_tile_edges();
        write_tile(0, 0, int'(SOLID_CODE));
        query_rect(1, 1, 0, 0);
        query_rect(33, 1, 0, 0);
        write_tile(0, 0, 255);
    endtask

    // Only the exact solid code counts
    task automatic test_non_solid_codes();
        write_tile(7, 9, 3);
        query_rect(9*TILE_PIX + 1, 7*TILE_PIX + 1, 0, 0);
        write_tile(7, 9, int'(SOLID_CODE));
        query_rect(9*TILE_PIX + 1, 7*TILE_PIX + 1, 0, 0);
        write_tile(7, 9, 0);
    endtask

    // Small negative edges truncate toward zero and still land on tile zero
    task automatic test_negative_truncation();
        write_tile(0, 0, int'(SOLID_CODE));
        query_rect(-30, -30, 0, 0);
        query_rect(-2048, 5, 2047, 0);
        write_tile(0, 0, 0);
    endtask

    // Fields of the other item kind must not matter
    task automatic test_unused_fields();
        send_item(MODE_QUERY, 4'hf, 5'h1f, 8'hff, 12'sd1, 12'sd1, 11'd0, 11'd0);
        query_rect((COLS-1)*TILE_PIX + 1, (ROWS-1)*TILE_PIX + 1, 0, 0);
        send_item(MODE_WRITE, 4'd3, 5'd3, SOLID_CODE, 12'hfff, 12'hfff, 11'h7ff, 11'h7ff);
        query_rect(3*TILE_PIX + 1, 3*TILE_PIX + 1, 0, 0);
        write_tile(3, 3, 0);
    endtask

    // Queries keep coming while the result side is held off, so the core backs up
    task automatic test_output_hold();
        bit keep_idle;
        keep_idle = idle_on;
        write_tile(2, 2, int'(SOLID_CODE));
        idle_on = 1'b0;
        hold_go = 1'b1;
        for (int i = 0; i < 40; i++)
            query_rect($urandom_range(0, 160) - 16, $urandom_range(0, 160) - 16,
                       $urandom_range(0, 48), $urandom_range(0, 48));
        idle_on = keep_idle;
    endtask

    // Mixed writes and queries, mostly sprite-sized rectangles
    task automatic test_random_traffic();
        int sel, v;
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            // Switch idling per stretch, leaving some stretches back to back
            if (i % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                v = $urandom_range(0, 99);
                if (v < 15)
                    v = int'(SOLID_CODE);
                else if (v < 25)
                    v = 0;
                else
                    v = $urandom_range(0, 255);
                write_tile($urandom_range(0, ROWS-1), $urandom_range(0, COLS-1), v);
            end
            else if (sel < 90)
                query_rect($urandom_range(0, 1100) - 40, $urandom_range(0, 580) - 40,
                           $urandom_range(0, 80), $urandom_range(0, 80));
            else if (sel < 96)
                query_rect($urandom(), $urandom(), $urandom(), $urandom());
            else
                query_rect($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                           $urandom_range(900, 2047), $urandom_range(400, 2047));
        end
        idle_on = 1'b1;
    endtask

    initial
    begin : run_tests
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_map_load();
        test_empty_ranges();
        test_full_map_scan();
        test_single_tile_edges();
        test_non_solid_codes();
        test_negative_truncation();
        test_unused_fields();
        test_output_hold();
        test_random_traffic();

        // Drop valid after the last beat and drain the owed results
        s_tvalid <= 1'b0;
        while (hit_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0 && hit_due_q.size() == 0)
            $display("tile_map_rect_collision_core regression: pass");
        else
            $display("tile_map_rect_collision_core regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
design/tmrc_pkg.sv
design/tmrc_ram.sv
design/tile_map_rect_collision_core.sv
tb/tb_tile_map_rect_collision_core.sv
